/* hdl/cmci_pkg.sv */
// ----------------------------------------------------------------------------
// cmci_pkg
// Shared types and constants of the circular merge cost interval DP core.
// ----------------------------------------------------------------------------
`default_nettype none

package cmci_pkg;

  localparam int DEF_MAX_PILES   = 64;
  localparam int DEF_WEIGHT_BITS = 16;
  localparam int IN_WEIGHT_W     = 16;
  localparam int COST_W          = 32;
  localparam int ACC_W           = COST_W + 1;

  typedef struct packed {
    logic [IN_WEIGHT_W-1:0] weight;
    logic                   last;
  } in_req_t;

  typedef struct packed {
    logic [COST_W-1:0] min_cost;
    logic [COST_W-1:0] max_cost;
  } out_req_t;

  // One entry of the interval cost table.
  typedef struct packed {
    logic [COST_W-1:0] min_cost;
    logic [COST_W-1:0] max_cost;
  } cost_pair_t;

  // Control that travels with one split-point read.
  typedef struct packed {
    logic valid;
    logic first;   // first split point: left part is a single pile
    logic last_k;  // last split point: right part is a single pile
    logic zero_l;  // left prefix is entry zero
    logic wrap_l;  // left prefix lies in the second copy of the circle
    logic wrap_r;  // right prefix lies in the second copy of the circle
  } issue_ctl_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ISSUE,
    ST_DRAIN,
    ST_SWEEP,
    ST_SWEEP_END,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

/* hdl/circular_merge_cost_interval_dp_core.sv */
// ----------------------------------------------------------------------------
// circular_merge_cost_interval_dp_core
// Least and greatest cost of merging a circle of piles into one pile.
// ----------------------------------------------------------------------------
// Usage:
//   Send pile weights on the in_ channel, one request per cycle, in circular
//   order; set last on the final pile. Weights past MAX_PILES are dropped, but
//   a last request still closes the circle. One out_ request per circle
//   carries min_cost and max_cost; a single pile gives zero for both.
//   After the last weight in_ready drops while the solver runs over the cost
//   table memory: for n piles it issues one pair of table reads per split
//   point, drains the pipeline after each interval length and then runs the
//   rotation sweep. The two read ports of the cost memory set its pace.
//   The result sits in an output register. If the receiver stalls, loading
//   of the next circle goes on; only a finished solve waits for the register.
//   Reset (rst_n low, synchronous) empties the pile count and the output.
//   The cost table needs no clearing: every entry is written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_merge_cost_interval_dp_core
  import cmci_pkg::*;
#(
  parameter int MAX_PILES   = DEF_MAX_PILES,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire in_req_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output out_req_t     out_data
);

  localparam int LW = $clog2(2 * MAX_PILES);      // index into doubled circle
  localparam int CW = $clog2(MAX_PILES + 1);      // pile count
  localparam int PW = WEIGHT_BITS + CW;           // prefix sum

  state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] run_sum_r, run_sum_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [LW-1:0] l_r, l_nxt, k_r, k_nxt;
  logic          sw_v_r, sw_v_nxt, sw_first_r, sw_first_nxt;
  logic [COST_W-1:0] best_min_r, best_min_nxt, best_max_r, best_max_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_req_t      out_data_r, out_data_nxt;

  logic             accept, room, go_solve, out_load, sweep_rd;
  logic [WEIGHT_BITS-1:0] w_ext;
  logic [CW-1:0]    cnt_inc, cnt_after;
  logic [LW-1:0]    r_idx, sw_r_idx;
  logic [LW:0]      m_last, n_ext, jl, jr;
  logic             k_last, int_last, len_done, sw_last, busy;
  issue_ctl_t       iss_ctl;

  logic [CW-1:0]    pre_addr_l, pre_addr_r;
  logic [PW-1:0]    pre_l, pre_r;
  logic             pre_we;
  logic [PW-1:0]    pre_wdata;

  logic [2*LW-1:0]  cost_raddr_a, cost_raddr_b, cost_waddr;
  logic             cost_we;
  cost_pair_t       cost_rd_a, cost_rd_b, cost_wdata;

  // --------------------------------------------------------------------------
  // Index arithmetic
  // --------------------------------------------------------------------------
  always_comb begin
    accept    = in_valid & in_ready;
    room      = cnt_r < CW'(MAX_PILES);
    w_ext     = WEIGHT_BITS'(in_data.weight);
    cnt_inc   = cnt_r + CW'(1);
    cnt_after = room ? cnt_inc : cnt_r;
    go_solve  = cnt_after > CW'(1);

    r_idx     = l_r + LW'(len_r) - LW'(1);
    n_ext     = (LW+1)'(cnt_r);
    m_last    = (n_ext << 1) - (LW+1)'(1);
    k_last    = k_r == r_idx;
    int_last  = (LW+1)'(r_idx) == m_last;
    len_done  = len_r == cnt_r;
    sw_r_idx  = l_r + LW'(cnt_r) - LW'(1);
    sw_last   = l_r == (LW'(cnt_r) - LW'(1));

    // Positions past n map back onto the first copy plus the circle total.
    jl         = (LW+1)'(l_r);
    jr         = (LW+1)'(r_idx) + (LW+1)'(1);
    pre_addr_l = (jl > n_ext) ? CW'(jl - n_ext) : CW'(jl);
    pre_addr_r = (jr > n_ext) ? CW'(jr - n_ext) : CW'(jr);
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (accept && in_data.last) begin
          state_nxt = go_solve ? ST_ISSUE : ST_OUT;
        end
      end
      ST_ISSUE: begin
        if (k_last && int_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!busy) begin
          state_nxt = len_done ? ST_SWEEP : ST_ISSUE;
        end
      end
      ST_SWEEP: begin
        if (sw_last) begin
          state_nxt = ST_SWEEP_END;
        end
      end
      ST_SWEEP_END: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // State outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready = 1'b0;
    sweep_rd = 1'b0;
    out_load = 1'b0;
    iss_ctl  = '0;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
      end
      ST_ISSUE: begin
        iss_ctl.valid = 1'b1;
      end
      ST_SWEEP: begin
        sweep_rd = 1'b1;
      end
      ST_OUT: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    iss_ctl.first  = k_r == (l_r + LW'(1));
    iss_ctl.last_k = k_last;
    iss_ctl.zero_l = l_r == '0;
    iss_ctl.wrap_l = jl > n_ext;
    iss_ctl.wrap_r = jr > n_ext;
  end

  // --------------------------------------------------------------------------
  // Load path: write running prefix sums
  // --------------------------------------------------------------------------
  always_comb begin
    pre_we    = accept && room;
    pre_wdata = run_sum_r + PW'(w_ext);
  end

  // --------------------------------------------------------------------------
  // Sequencer and result registers
  // --------------------------------------------------------------------------
  always_comb begin
    cnt_nxt      = cnt_r;
    run_sum_nxt  = run_sum_r;
    len_nxt      = len_r;
    l_nxt        = l_r;
    k_nxt        = k_r;
    best_min_nxt = best_min_r;
    best_max_nxt = best_max_r;
    sw_v_nxt     = sweep_rd;
    sw_first_nxt = sweep_rd && (l_r == '0);

    // Load: count piles, accumulate; start the solve on the last pile.
    if (pre_we) begin
      cnt_nxt     = cnt_inc;
      run_sum_nxt = pre_wdata;
    end
    if (accept && in_data.last) begin
      len_nxt = CW'(2);
      l_nxt   = '0;
      k_nxt   = LW'(1);
      if (!go_solve) begin
        best_min_nxt = '0;
        best_max_nxt = '0;
      end
    end

    // Issue one split point per cycle; advance interval, then length.
    if (state_r == ST_ISSUE) begin
      if (k_last) begin
        if (!int_last) begin
          l_nxt = l_r + LW'(1);
          k_nxt = l_r + LW'(2);
        end
      end else begin
        k_nxt = k_r + LW'(1);
      end
    end
    if (state_r == ST_DRAIN && !busy) begin
      l_nxt = '0;
      k_nxt = LW'(1);
      if (!len_done) begin
        len_nxt = len_r + CW'(1);
      end
    end

    // Sweep the n windows of length n; keep the best.
    if (sweep_rd) begin
      l_nxt = l_r + LW'(1);
    end
    if (sw_v_r) begin
      if (sw_first_r || cost_rd_a.min_cost < best_min_r) begin
        best_min_nxt = cost_rd_a.min_cost;
      end
      if (sw_first_r || cost_rd_a.max_cost > best_max_r) begin
        best_max_nxt = cost_rd_a.max_cost;
      end
    end

    // Hand off to the output register and reopen for a new circle.
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.min_cost = best_min_r;
      out_data_nxt.max_cost = best_max_r;
      cnt_nxt               = '0;
      run_sum_nxt           = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      run_sum_r   <= '0;
      sw_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      run_sum_r   <= run_sum_nxt;
      sw_v_r      <= sw_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    l_r        <= l_nxt;
    k_r        <= k_nxt;
    sw_first_r <= sw_first_nxt;
    best_min_r <= best_min_nxt;
    best_max_r <= best_max_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Cost table addressing: port A reads the left part (or a sweep window),
  // port B the right part.
  // --------------------------------------------------------------------------
  always_comb begin
    cost_raddr_a = sweep_rd ? {l_r, sw_r_idx} : {l_r, k_r - LW'(1)};
    cost_raddr_b = {k_r, r_idx};
  end

  cmci_prefix_ram #(
    .AW    (CW),
    .DW    (PW),
    .DEPTH (MAX_PILES + 1)
  ) u_prefix_ram (
    .clk     (clk),
    .we      (pre_we),
    .waddr   (cnt_inc),
    .wdata   (pre_wdata),
    .raddr_a (pre_addr_l),
    .raddr_b (pre_addr_r),
    .rdata_a (pre_l),
    .rdata_b (pre_r)
  );

  cmci_cost_ram #(
    .AW (2 * LW)
  ) u_cost_ram (
    .clk     (clk),
    .we      (cost_we),
    .waddr   (cost_waddr),
    .wdata   (cost_wdata),
    .raddr_a (cost_raddr_a),
    .raddr_b (cost_raddr_b),
    .rdata_a (cost_rd_a),
    .rdata_b (cost_rd_b)
  );

  cmci_interval_pipe #(
    .LW (LW),
    .PW (PW)
  ) u_interval_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .iss_ctl (iss_ctl),
    .iss_l   (l_r),
    .iss_r   (r_idx),
    .rd_a    (cost_rd_a),
    .rd_b    (cost_rd_b),
    .pre_l   (pre_l),
    .pre_r   (pre_r),
    .total   (run_sum_r),
    .busy    (busy),
    .wr_en   (cost_we),
    .wr_addr (cost_waddr),
    .wr_data (cost_wdata)
  );

endmodule

`default_nettype wire

/* hdl/cmci_prefix_ram.sv */
// ----------------------------------------------------------------------------
// cmci_prefix_ram
// Prefix sum memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module cmci_prefix_ram #(
  parameter int AW    = 7,
  parameter int DW    = 23,
  parameter int DEPTH = 65
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  output logic      [DW-1:0] rdata_a,
  output logic      [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

/* hdl/cmci_cost_ram.sv */
// ----------------------------------------------------------------------------
// cmci_cost_ram
// Interval cost table: min and max cost per entry, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module cmci_cost_ram
  import cmci_pkg::*;
#(
  parameter int AW = 14
) (
  input  wire logic       clk,
  input  wire logic       we,
  input  wire logic [AW-1:0] waddr,
  input  wire cost_pair_t wdata,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  output cost_pair_t      rdata_a,
  output cost_pair_t      rdata_b
);

  cost_pair_t mem [0:(2**AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

/* hdl/cmci_interval_pipe.sv */
// ----------------------------------------------------------------------------
// cmci_interval_pipe
// Split-point pipeline: sum the two part costs, fold min and max over the
// split points, add the interval weight and write the saturated result back.
// ----------------------------------------------------------------------------
`default_nettype none

module cmci_interval_pipe
  import cmci_pkg::*;
#(
  parameter int LW = 7,
  parameter int PW = 23
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire issue_ctl_t   iss_ctl,
  input  wire logic [LW-1:0] iss_l,
  input  wire logic [LW-1:0] iss_r,
  input  wire cost_pair_t   rd_a,
  input  wire cost_pair_t   rd_b,
  input  wire logic [PW-1:0] pre_l,
  input  wire logic [PW-1:0] pre_r,
  input  wire logic [PW-1:0] total,
  output logic              busy,
  output logic              wr_en,
  output logic [2*LW-1:0]   wr_addr,
  output cost_pair_t        wr_data
);

  localparam int TOT_W = ((ACC_W > PW) ? ACC_W : PW) + 1;

  // Stage 1: aligned with memory read data
  issue_ctl_t    p1_ctl_r;
  logic [LW-1:0] p1_l_r, p1_r_r;

  // Stage 2: part sums and interval weight
  logic             p2_v_r, p2_first_r, p2_last_r;
  logic [LW-1:0]    p2_l_r, p2_r_r;
  logic [ACC_W-1:0] p2_smin_r, p2_smax_r;
  logic [PW-1:0]    p2_span_r;

  // Stage 3: running min and max over split points
  logic             p3_v_r, p3_last_r;
  logic [LW-1:0]    p3_l_r, p3_r_r;
  logic [ACC_W-1:0] acc_min_r, acc_max_r;
  logic [PW-1:0]    p3_span_r;

  logic [COST_W-1:0] a_min, a_max, b_min, b_max;
  logic [ACC_W-1:0]  smin, smax, acc_min_nxt, acc_max_nxt;
  logic [PW-1:0]     pl_val;
  logic [PW:0]       ext_l, ext_r;
  logic [PW-1:0]     span;
  logic [TOT_W-1:0]  tot_min, tot_max;

  // Diagonal entries (single piles) cost nothing; skip the table for them.
  always_comb begin
    a_min  = p1_ctl_r.first  ? '0 : rd_a.min_cost;
    a_max  = p1_ctl_r.first  ? '0 : rd_a.max_cost;
    b_min  = p1_ctl_r.last_k ? '0 : rd_b.min_cost;
    b_max  = p1_ctl_r.last_k ? '0 : rd_b.max_cost;
    smin   = ACC_W'(a_min) + ACC_W'(b_min);
    smax   = ACC_W'(a_max) + ACC_W'(b_max);
    pl_val = p1_ctl_r.zero_l ? '0 : pre_l;
    ext_l  = (PW+1)'(pl_val) + (p1_ctl_r.wrap_l ? (PW+1)'(total) : '0);
    ext_r  = (PW+1)'(pre_r)  + (p1_ctl_r.wrap_r ? (PW+1)'(total) : '0);
    span   = PW'(ext_r - ext_l);
  end

  always_comb begin
    if (p2_first_r) begin
      acc_min_nxt = p2_smin_r;
      acc_max_nxt = p2_smax_r;
    end else begin
      acc_min_nxt = (p2_smin_r < acc_min_r) ? p2_smin_r : acc_min_r;
      acc_max_nxt = (p2_smax_r > acc_max_r) ? p2_smax_r : acc_max_r;
    end
  end

  // Saturate at the top of the cost range.
  always_comb begin
    tot_min = TOT_W'(acc_min_r) + TOT_W'(p3_span_r);
    tot_max = TOT_W'(acc_max_r) + TOT_W'(p3_span_r);
    wr_data.min_cost = (tot_min > TOT_W'({COST_W{1'b1}})) ? '1 : COST_W'(tot_min);
    wr_data.max_cost = (tot_max > TOT_W'({COST_W{1'b1}})) ? '1 : COST_W'(tot_max);
    wr_en   = p3_v_r & p3_last_r;
    wr_addr = {p3_l_r, p3_r_r};
    busy    = p1_ctl_r.valid | p2_v_r | p3_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_ctl_r <= '0;
      p2_v_r   <= 1'b0;
      p3_v_r   <= 1'b0;
    end else begin
      p1_ctl_r <= iss_ctl;
      p2_v_r   <= p1_ctl_r.valid;
      p3_v_r   <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_l_r     <= iss_l;
    p1_r_r     <= iss_r;
    p2_first_r <= p1_ctl_r.first;
    p2_last_r  <= p1_ctl_r.last_k;
    p2_l_r     <= p1_l_r;
    p2_r_r     <= p1_r_r;
    p2_smin_r  <= smin;
    p2_smax_r  <= smax;
    p2_span_r  <= span;
    p3_last_r  <= p2_last_r;
    p3_l_r     <= p2_l_r;
    p3_r_r     <= p2_r_r;
    p3_span_r  <= p2_span_r;
    if (p2_v_r) begin
      acc_min_r <= acc_min_nxt;
      acc_max_r <= acc_max_nxt;
    end
  end

endmodule

`default_nettype wire
